/* src/bss_pkg.sv */
// Package: shared types and constants of the batch size scheduler.
package bss_pkg;

   localparam int EPOCH_BITS = 16;

   localparam logic [2:0] REG_MODE      = 3'd0;
   localparam logic [2:0] REG_BASE      = 3'd1;
   localparam logic [2:0] REG_MAX       = 3'd2;
   localparam logic [2:0] REG_STEP      = 3'd3;
   localparam logic [2:0] REG_GAMMA     = 3'd4;
   localparam logic [2:0] REG_LR        = 3'd5;
   localparam logic [2:0] REG_LR_ENABLE = 3'd6;

   localparam logic OP_STEP  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [15:0] query_epoch;
   } req_type;

   typedef struct packed {
      logic [15:0] batch_size;
      logic [31:0] learning_rate;
      logic [15:0] epoch_now;
      logic        error;
   } rsp_type;

   typedef struct packed {
      logic        schedule_mode;
      logic [15:0] base_batch;
      logic [15:0] max_batch;
      logic [15:0] step_size;
      logic [31:0] gamma;
      logic [31:0] base_lr;
      logic        lr_enable;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // latch item, start k division
      logic div_k;      // one bit of epoch / step_size
      logic pow_init;   // acc = 1, sq = gamma<<8
      logic pow_err;    // overflowed square multiplied in
      logic mul_acc;    // start acc*sq
      logic mul_sq;     // start sq*sq
      logic mul_step;   // one 16-bit partial product of the multiplier
      logic mul_acc_wb; // write multiplier result to acc
      logic mul_sq_wb;  // write to sq
      logic shift_k;    // k >>= 1
      logic tdiv_init;
      logic lrdiv_init;
      logic div_step;   // one bit of the long divider
      logic lr_mul;     // latch target, round and clamp batch
      logic finish;     // build result, update epoch
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic k_bit;
      logic k_last;     // k >> 1 == 0
      logic sq_ovf;
      logic mul_ovf;
      logic step_mode;
      logic lr_on;
   } sts_type;

endpackage

/* src/bss_datapath.sv */
// Datapath: epoch counter, power by squaring, long divider and result register.
module bss_datapath (
   input  logic             clock,
   input  logic             reset,
   input  bss_pkg::cfg_type cfg,
   input  bss_pkg::req_type req,
   input  bss_pkg::cmd_type cmd,
   output bss_pkg::sts_type sts,
   output bss_pkg::rsp_type rsp
);
   localparam int EB = bss_pkg::EPOCH_BITS;
   localparam logic [EB-1:0] EMAX = {EB{1'b1}};

   logic [EB-1:0] epoch_ff, epoch_in;
   logic          is_step_ff;
   logic [EB-1:0] ep_ff;        // epoch being evaluated
   logic [EB-1:0] k_ff;         // exponent (quotient during k division)
   logic [15:0]   krem_ff;      // remainder of k division
   logic [63:0]   acc_ff, sq_ff;
   logic          sq_ovf_ff, mul_ovf_ff;
   logic [63:0]   ma_ff, mb_ff;
   logic [127:0]  prod_ff;
   logic [1:0]    ai_ff, bi_ff;
   logic [63:0]   num_ff;       // dividend shifted out top first
   logic [63:0]   rem_ff;
   logic [63:0]   den_ff;
   logic [63:0]   quo_ff;
   logic [47:0]   target_ff;
   logic [15:0]   batch_ff;
   logic          err_ff;
   bss_pkg::rsp_type rsp_ff;

   logic [15:0] step_eff;
   assign step_eff = (cfg.step_size == 16'd0) ? 16'd1 : cfg.step_size;

   // k division remainder step
   logic [16:0] kr_sh;
   assign kr_sh = {krem_ff, ep_ff[EB-1]};

   // multiplier partial product
   logic [31:0] pp;
   assign pp = 32'(ma_ff[ai_ff*16 +: 16]) * 32'(mb_ff[bi_ff*16 +: 16]);

   // rounded Q32.32 product
   logic [95:0] rounded;
   assign rounded = prod_ff[127:32] + {95'd0, prod_ff[31]};

   // long division step
   logic [64:0] rsh;
   logic        ge;
   assign rsh = {rem_ff, num_ff[63]};
   assign ge  = rsh >= {1'b0, den_ff};

   logic [63:0] lrnum;
   assign lrnum = 64'(cfg.base_lr) * 64'(batch_ff);

   // rate above 32 bits, or numerator above 48 bits, on a compensated step
   logic rate_err;
   assign rate_err = is_step_ff && cfg.lr_enable && !err_ff &&
                     (lrnum[63:48] != 16'd0 || quo_ff[63:32] != 32'd0);

   always_comb begin
      epoch_in = epoch_ff;
      if (cmd.finish && is_step_ff && !err_ff && !rate_err) epoch_in = ep_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= '0;
      end else begin
         epoch_ff <= epoch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_step_ff <= (req.operation == bss_pkg::OP_STEP);
         if (req.operation == bss_pkg::OP_QUERY) ep_ff <= EB'(req.query_epoch);
         else ep_ff <= (epoch_ff == EMAX) ? EMAX : epoch_ff + 1'b1;
         k_ff    <= '0;
         krem_ff <= '0;
         err_ff  <= 1'b0;
      end
      if (cmd.div_k) begin
         // restoring division, epoch bits rotate through ep_ff
         ep_ff <= {ep_ff[EB-2:0], ep_ff[EB-1]};
         if (kr_sh >= {1'b0, step_eff}) begin
            krem_ff <= 16'(kr_sh - {1'b0, step_eff});
            k_ff    <= {k_ff[EB-2:0], 1'b1};
         end else begin
            krem_ff <= kr_sh[15:0];
            k_ff    <= {k_ff[EB-2:0], 1'b0};
         end
      end
      if (cmd.pow_init) begin
         if (cfg.schedule_mode) k_ff <= ep_ff;
         acc_ff     <= 64'h1_0000_0000;
         sq_ff      <= {24'd0, cfg.gamma, 8'd0};
         sq_ovf_ff  <= 1'b0;
         mul_ovf_ff <= 1'b0;
      end
      if (cmd.pow_err) err_ff <= 1'b1;
      if (cmd.mul_acc || cmd.mul_sq) begin
         ma_ff   <= cmd.mul_acc ? acc_ff : sq_ff;
         mb_ff   <= sq_ff;
         prod_ff <= '0;
         ai_ff   <= '0;
         bi_ff   <= '0;
      end
      if (cmd.mul_step) begin
         prod_ff <= prod_ff + (128'(pp) << (ai_ff*16 + bi_ff*16));
         bi_ff   <= bi_ff + 1'b1;
         if (bi_ff == 2'd3) ai_ff <= ai_ff + 1'b1;
      end
      if (cmd.mul_acc_wb) begin
         acc_ff <= rounded[63:0];
         if (rounded[95:64] != 32'd0) mul_ovf_ff <= 1'b1;
      end
      if (cmd.mul_sq_wb) begin
         sq_ff <= rounded[63:0];
         if (rounded[95:64] != 32'd0) sq_ovf_ff <= 1'b1;
      end
      if (cmd.shift_k) k_ff <= k_ff >> 1;
      if (cmd.tdiv_init) begin
         num_ff <= {cfg.base_batch, 48'd0};   // base_batch << 48
         den_ff <= acc_ff;
         rem_ff <= '0;
         quo_ff <= '0;
         if (mul_ovf_ff || acc_ff == 64'd0) err_ff <= 1'b1;
      end
      if (cmd.lrdiv_init) begin
         num_ff <= {lrnum[47:0], 16'd0};      // (base_lr * batch) << 16
         den_ff <= {16'd0, target_ff};
         rem_ff <= '0;
         quo_ff <= '0;
      end
      if (cmd.div_step) begin
         num_ff <= {num_ff[62:0], 1'b0};
         rem_ff <= ge ? 64'(rsh - {1'b0, den_ff}) : rsh[63:0];
         quo_ff <= {quo_ff[62:0], ge};
      end
      if (cmd.lr_mul) begin
         // target needs quotient < 2^48 and above zero
         target_ff <= quo_ff[47:0];
         if (quo_ff[63:48] != 16'd0 || quo_ff == 64'd0) err_ff <= 1'b1;
         begin
            logic [32:0] r;
            r = 33'((49'(quo_ff[47:0]) + 49'h8000) >> 16);
            if (r == 33'd0) batch_ff <= 16'd1;
            else if (r > {17'd0, cfg.max_batch}) batch_ff <= cfg.max_batch;
            else batch_ff <= r[15:0];
         end
      end
      if (cmd.finish) begin
         logic e;
         e = err_ff || rate_err;
         rsp_ff.error         <= e;
         rsp_ff.batch_size    <= e ? 16'd0 : batch_ff;
         rsp_ff.learning_rate <= (e || !is_step_ff || !cfg.lr_enable) ? 32'd0
                                 : quo_ff[31:0];
         rsp_ff.epoch_now     <= 16'((is_step_ff && !e) ? ep_ff : epoch_ff);
      end
   end

   assign sts.k_bit     = k_ff[0];
   assign sts.k_last    = (k_ff >> 1) == '0;
   assign sts.sq_ovf    = sq_ovf_ff;
   assign sts.mul_ovf   = mul_ovf_ff;
   assign sts.step_mode = !cfg.schedule_mode;
   assign sts.lr_on     = cfg.lr_enable && is_step_ff && !err_ff;
   assign rsp = rsp_ff;
endmodule

/* src/bss_control.sv */
// Controller: sequences k division, power, divisions and the handshakes.
module bss_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  bss_pkg::sts_type sts,
   output bss_pkg::cmd_type cmd
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_KDIV  = 4'd1;
   localparam logic [3:0] S_PINIT = 4'd2;
   localparam logic [3:0] S_PBIT  = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_WB    = 4'd5;
   localparam logic [3:0] S_TDIV  = 4'd6;
   localparam logic [3:0] S_TDONE = 4'd7;
   localparam logic [3:0] S_LRDIV = 4'd8;
   localparam logic [3:0] S_FIN   = 4'd9;
   localparam logic [3:0] S_OUT   = 4'd10;
   localparam logic [3:0] S_LRI   = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [6:0] cnt_ff, cnt_in;
   logic       sqmode_ff, sqmode_in;   // current multiply is a square
   logic       done_ff, done_in;       // current exponent bit handled (multiplied in or aborted)

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      sqmode_in = sqmode_ff;
      done_in   = done_ff;
      req_ready = (state_ff == S_IDLE);
      rsp_valid = (state_ff == S_OUT);
      case (state_ff)
         S_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            cnt_in   = '0;
            state_in = S_KDIV;
         end
         S_KDIV: begin
            if (!sts.step_mode) state_in = S_PINIT;
            else begin
               cmd.div_k = 1'b1;
               cnt_in    = cnt_ff + 1'b1;
               if (cnt_ff == 7'(bss_pkg::EPOCH_BITS - 1)) state_in = S_PINIT;
            end
         end
         S_PINIT: begin
            cmd.pow_init = 1'b1;
            done_in      = 1'b0;
            state_in     = S_PBIT;
         end
         S_PBIT: begin
            if (sts.mul_ovf) state_in = S_TDIV;
            else if (sqmode_ff == 1'b0 && sts.k_bit && !done_ff) begin
               if (sts.sq_ovf) begin
                  // overflowed square multiplied in: error
                  cmd.pow_err = 1'b1;
                  state_in    = S_TDIV;
                  done_in     = 1'b1;
               end else begin
                  cmd.mul_acc = 1'b1;
                  cnt_in      = '0;
                  state_in    = S_MUL;
               end
            end else if (sts.k_last) state_in = S_TDIV;
            else if (sqmode_ff == 1'b0 && !sts.sq_ovf) begin
               cmd.mul_sq = 1'b1;
               sqmode_in  = 1'b1;
               cnt_in     = '0;
               state_in   = S_MUL;
            end else begin
               cmd.shift_k = 1'b1;
               sqmode_in   = 1'b0;
               done_in     = 1'b0;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == 7'd15) state_in = S_WB;
         end
         S_WB: begin
            if (sqmode_ff) begin
               cmd.mul_sq_wb = 1'b1;
               cmd.shift_k   = 1'b1;
               sqmode_in     = 1'b0;
               done_in       = 1'b0;
            end else begin
               cmd.mul_acc_wb = 1'b1;
               done_in        = 1'b1;
            end
            state_in = S_PBIT;
         end
         S_TDIV: begin
            if (cnt_ff == 7'd0 && state_ff == S_TDIV && !sqmode_ff) begin
               cmd.tdiv_init = 1'b1;
               sqmode_in     = 1'b1;
               cnt_in        = 7'd1;
            end else begin
               cmd.div_step = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
               if (cnt_ff == 7'd64) state_in = S_TDONE;
            end
         end
         S_TDONE: begin
            cmd.lr_mul = 1'b1;
            sqmode_in  = 1'b0;
            state_in   = S_LRI;
         end
         S_LRI: begin
            if (sts.lr_on) begin
               cmd.lrdiv_init = 1'b1;
               cnt_in         = 7'd1;
               state_in       = S_LRDIV;
            end else state_in = S_FIN;
         end
         S_LRDIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == 7'd64) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      // entering TDIV: counter must start at zero
      if (state_in == S_TDIV && state_ff != S_TDIV) begin
         cnt_in    = '0;
         sqmode_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         sqmode_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         sqmode_ff <= sqmode_in;
         done_ff   <= done_in;
      end
   end
endmodule

/* src/batch_size_scheduler.sv */
// Top level: batch size scheduler with configuration registers.
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | req_data (req_type)
//  rsp     | out       | rsp_valid / rsp_ready  | rsp_data (rsp_type)
//  csr     | in        | csr_valid / csr_ready  | csr_index, csr_data
// From acceptance to result valid an item goes through a 16-bit epoch division
// in step mode, an issue, 16 partial products and a write-back per set exponent
// bit and per square, a 64-bit target division and a 64-bit rate division on
// compensated steps.
// One item is in flight at a time; the next is taken after the result is
// delivered. Reset clears the epoch counter and registers to their defaults.
// csr writes are always ready.
module batch_size_scheduler (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bss_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_data
);
   bss_pkg::cfg_type cfg_ff;
   bss_pkg::cmd_type cmd;
   bss_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{schedule_mode: 1'b0, base_batch: 16'd1, max_batch: 16'd1,
                     step_size: 16'd1, gamma: 32'h0100_0000, base_lr: 32'd0,
                     lr_enable: 1'b0};
      end else if (csr_valid) begin
         case (csr_index)
            bss_pkg::REG_MODE:      cfg_ff.schedule_mode <= csr_data[0];
            bss_pkg::REG_BASE:      cfg_ff.base_batch    <= csr_data[15:0];
            bss_pkg::REG_MAX:       cfg_ff.max_batch     <= csr_data[15:0];
            bss_pkg::REG_STEP:      cfg_ff.step_size     <= csr_data[15:0];
            bss_pkg::REG_GAMMA:     cfg_ff.gamma         <= csr_data;
            bss_pkg::REG_LR:        cfg_ff.base_lr       <= csr_data;
            bss_pkg::REG_LR_ENABLE: cfg_ff.lr_enable     <= csr_data[0];
            default: ;
         endcase
      end
   end

   bss_control u_control (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   bss_datapath u_datapath (
      .clock, .reset, .cfg(cfg_ff), .req(req_data), .cmd, .sts, .rsp(rsp_data)
   );
endmodule

/* tb/batch_size_scheduler_tb.sv */
// Testbench: batch size scheduler checked item by item against a fixed-point schedule model.
`timescale 1ns / 100ps

module batch_size_scheduler_tb;

   localparam int HANG_LIMIT = 40000;
   localparam int PHASE_ITEMS = 316;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   bss_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   bss_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [2:0] csr_index;
   logic [31:0] csr_data;

   batch_size_scheduler uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // shadow of the schedule registers and epoch counter
   logic        sh_mode;
   logic [15:0] sh_base;
   logic [15:0] sh_max;
   logic [15:0] sh_step;
   logic [31:0] sh_gamma;
   logic [31:0] sh_lr;
   logic        sh_lr_en;
   logic [15:0] sh_epoch;

   bss_pkg::rsp_type expected_rsps[$];
   int fail_count = 0;
   int items_sent = 0;
   int rsps_seen = 0;
   int err_rsps = 0;
   int idle_cycles = 0;
   int send_idle = 0;
   int recv_idle = 0;

   typedef struct {
      bit               is_cfg;
      logic [2:0]       idx;
      logic [31:0]      data;
      bss_pkg::req_type rq;
      bit               chk;
      bss_pkg::rsp_type ex;
   } dir_row_type;

   dir_row_type dir_rows [26] = '{
      '{0, bss_pkg::REG_MODE, 0, '{bss_pkg::OP_STEP, 16'd0}, 1,
        '{16'd1, 32'd0, 16'd1, 1'b0}},
      '{0, bss_pkg::REG_MODE, 0, '{bss_pkg::OP_QUERY, 16'd0}, 1,
        '{16'd1, 32'd0, 16'd1, 1'b0}},
      '{0, bss_pkg::REG_MODE, 0, '{bss_pkg::OP_QUERY, 16'hFFFF}, 1,
        '{16'd1, 32'd0, 16'd1, 1'b0}},
      '{1, bss_pkg::REG_GAMMA, 32'd0, '{bss_pkg::OP_STEP, 16'd0}, 0,
        '{16'd0, 32'd0, 16'd0, 1'b0}},
      '{0, bss_pkg::REG_MODE, 0, '{bss_pkg::OP_QUERY, 16'd3}, 1,
        '{16'd0, 32'd0, 16'd1, 1'b1}},
      '{0, bss_pkg::REG_MODE, 0, '{bss_pkg::OP_STEP, 16'hFFFF}, 1,
        '{16'd0, 32'd0, 16'd1, 1'b1}},
      '{0, bss_pkg::REG_MODE, 0, '{bss_pkg::OP_QUERY, 16'd0}, 1,
        '{16'd1, 32'd0, 16'd1, 1'b0}},
      '{1, bss_pkg::REG_GAMMA, 32'hFFFF_FFFF, '{bss_pkg::OP_STEP, 16'd0}, 0,
        '{16'd0, 32'd0, 16'd0, 1'b0}},
      '{1, bss_pkg::REG_BASE, 32'hFFFF, '{bss_pkg::OP_STEP, 16'd0}, 0,
        '{16'd0, 32'd0, 16'd0, 1'b0}},
      '{1, bss_pkg::REG_MAX, 32'hFFFF, '{bss_pkg::OP_STEP, 16'd0}, 0,
        '{16'd0, 32'd0, 16'd0, 1'b0}},
      '{1, bss_pkg::REG_LR, 32'hFFFF_FFFF, '{bss_pkg::OP_STEP, 16'd0}, 0,
        '{16'd0, 32'd0, 16'd0, 1'b0}},
      '{1, bss_pkg::REG_LR_ENABLE, 32'd1, '{bss_pkg::OP_STEP, 16'd0}, 0,
        '{16'd0, 32'd0, 16'd0, 1'b0}},
      '{0, bss_pkg::REG_MODE, 0, '{bss_pkg::OP_QUERY, 16'd0}, 1,
        '{16'hFFFF, 32'd0, 16'd1, 1'b0}},
      '{0, bss_pkg::REG_MODE, 0, '{bss_pkg::OP_STEP, 16'd0}, 0,
        '{16'd0, 32'd0, 16'd0, 1'b0}},
      '{0, bss_pkg::REG_MODE, 0, '{bss_pkg::OP_QUERY, 16'hFFFF}, 0,
        '{16'd0, 32'd0, 16'd0, 1'b0}},
      '{1, bss_pkg::REG_MODE, 32'd1, '{bss_pkg::OP_STEP, 16'd0}, 0,
        '{16'd0, 32'd0, 16'd0, 1'b0}},
      '{1, bss_pkg::REG_STEP, 32'd0, '{bss_pkg::OP_STEP, 16'd0}, 0,
        '{16'd0, 32'd0, 16'd0, 1'b0}},
      '{1, bss_pkg::REG_MAX, 32'd0, '{bss_pkg::OP_STEP, 16'd0}, 0,
        '{16'd0, 32'd0, 16'd0, 1'b0}},
      '{1, bss_pkg::REG_GAMMA, 32'h0100_0000, '{bss_pkg::OP_STEP, 16'd0}, 0,
        '{16'd0, 32'd0, 16'd0, 1'b0}},
      '{0, bss_pkg::REG_MODE, 0, '{bss_pkg::OP_STEP, 16'd0}, 0,
        '{16'd0, 32'd0, 16'd0, 1'b0}},
      '{0, bss_pkg::REG_MODE, 0, '{bss_pkg::OP_QUERY, 16'd9}, 0,
        '{16'd0, 32'd0, 16'd0, 1'b0}},
      '{1, bss_pkg::REG_MODE, 32'd0, '{bss_pkg::OP_STEP, 16'd0}, 0,
        '{16'd0, 32'd0, 16'd0, 1'b0}},
      '{1, bss_pkg::REG_GAMMA, 32'd1, '{bss_pkg::OP_STEP, 16'd0}, 0,
        '{16'd0, 32'd0, 16'd0, 1'b0}},
      '{0, bss_pkg::REG_MODE, 0, '{bss_pkg::OP_QUERY, 16'd1}, 0,
        '{16'd0, 32'd0, 16'd0, 1'b0}},
      '{0, bss_pkg::REG_MODE, 0, '{bss_pkg::OP_QUERY, 16'd2}, 0,
        '{16'd0, 32'd0, 16'd0, 1'b0}},
      '{0, bss_pkg::REG_MODE, 0, '{bss_pkg::OP_STEP, 16'd0}, 0,
        '{16'd0, 32'd0, 16'd0, 1'b0}}
   };

   // Q32.32 product rounded half up; returns overflow
   function automatic logic q32_product(input logic [63:0] a, input logic [63:0] b,
                                        output logic [63:0] r);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b} + 128'h8000_0000;
      r = p[95:32];
      return |p[127:96];
   endfunction

   function automatic logic gamma_power(input logic [15:0] k, output logic [63:0] pw);
      logic [63:0] acc;
      logic [63:0] sq;
      logic [63:0] tmp;
      logic sq_ovf;
      acc = 64'h1_0000_0000;
      sq = {24'd0, sh_gamma, 8'd0};
      sq_ovf = 1'b0;
      pw = 64'd0;
      for (int i = 0; i < 16; i++) begin
         if (k[i]) begin
            if (sq_ovf) return 1'b1;
            if (q32_product(acc, sq, tmp)) return 1'b1;
            acc = tmp;
         end
         if ((k >> (i + 1)) == 0) break;
         // an overflowed square only matters if it gets multiplied in
         if (!sq_ovf) begin
            sq_ovf = q32_product(sq, sq, tmp);
            sq = tmp;
         end
      end
      pw = acc;
      return 1'b0;
   endfunction

   function automatic logic batch_for_epoch(input logic [15:0] epoch,
                                            output logic [63:0] target,
                                            output logic [63:0] batch);
      logic [15:0] k;
      logic [63:0] pw;
      logic [63:0] t;
      logic [63:0] rnd;
      target = 64'd0;
      batch = 64'd0;
      if (sh_mode) k = epoch;
      else k = epoch / ((sh_step == 16'd0) ? 16'd1 : sh_step);
      if (gamma_power(k, pw) || pw == 64'd0) return 1'b1;
      t = {sh_base, 48'd0} / pw;
      if (t == 64'd0 || t[63:48] != 16'd0) return 1'b1;
      rnd = (t + 64'h8000) >> 16;
      if (rnd < 64'd1) rnd = 64'd1;
      else if (rnd > {48'd0, sh_max}) rnd = {48'd0, sh_max};
      target = t;
      batch = rnd;
      return 1'b0;
   endfunction

   function automatic bss_pkg::rsp_type schedule_result(input bss_pkg::req_type rq);
      bss_pkg::rsp_type o;
      logic err;
      logic [63:0] target;
      logic [63:0] batch;
      logic [63:0] rate;
      logic [15:0] next;
      rate = 64'd0;
      if (rq.operation == bss_pkg::OP_QUERY) begin
         err = batch_for_epoch(rq.query_epoch, target, batch);
      end else begin
         next = (sh_epoch != 16'hFFFF) ? sh_epoch + 16'd1 : sh_epoch;
         err = batch_for_epoch(next, target, batch);
         if (!err && sh_lr_en) begin
            rate = (({32'd0, sh_lr} * batch) << 16) / target;
            if (rate[63:32] != 32'd0) err = 1'b1;
         end
         if (!err) sh_epoch = next;
      end
      if (err) begin
         batch = 64'd0;
         rate = 64'd0;
      end
      o.batch_size = batch[15:0];
      o.learning_rate = rate[31:0];
      o.epoch_now = sh_epoch;
      o.error = err;
      return o;
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input bss_pkg::req_type rq, input bit chk,
                            input bss_pkg::rsp_type ex);
      if (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (chk) begin
         void'(schedule_result(rq));
         expected_rsps.push_back(ex);
      end else begin
         expected_rsps.push_back(schedule_result(rq));
      end
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_items();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // called at a falling edge, returns at a falling edge with csr_valid low
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         bss_pkg::REG_MODE:      sh_mode = data[0];
         bss_pkg::REG_BASE:      sh_base = data[15:0];
         bss_pkg::REG_MAX:       sh_max = data[15:0];
         bss_pkg::REG_STEP:      sh_step = data[15:0];
         bss_pkg::REG_GAMMA:     sh_gamma = data;
         bss_pkg::REG_LR:        sh_lr = data;
         bss_pkg::REG_LR_ENABLE: sh_lr_en = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick16(input bit allow_zero);
      case ($urandom_range(5))
         0: return 32'd1;
         1: return 32'hFFFF;
         2: return allow_zero ? 32'd0 : 32'd2;
         3: return $urandom_range(1, 8);
         default: return $urandom_range(1, 65535);
      endcase
   endfunction

   task automatic random_settings();
      logic [31:0] g;
      logic [31:0] lr;
      case ($urandom_range(6))
         0: g = 32'h0100_0000;
         1: g = $urandom;
         2: g = 32'hFFFF_FFFF;
         3: g = $urandom_range(1, 255);
         4: g = $urandom_range(32'h00F0_0000, 32'h0110_0000);
         default: g = $urandom_range(32'h0080_0000, 32'h0200_0000);
      endcase
      case ($urandom_range(3))
         0: lr = 32'd0;
         1: lr = 32'hFFFF_FFFF;
         default: lr = $urandom;
      endcase
      drain_items();
      write_reg(bss_pkg::REG_MODE, $urandom_range(1));
      write_reg(bss_pkg::REG_BASE, pick16(1'b0));
      write_reg(bss_pkg::REG_MAX, ($urandom_range(9) == 0) ? 32'd0 : pick16(1'b0));
      write_reg(bss_pkg::REG_STEP, ($urandom_range(9) == 0) ? 32'd0 : pick16(1'b0));
      write_reg(bss_pkg::REG_GAMMA, g);
      write_reg(bss_pkg::REG_LR, lr);
      write_reg(bss_pkg::REG_LR_ENABLE, $urandom_range(1));
   endtask

   task automatic random_phase(input int s_idle, input int r_idle);
      bss_pkg::req_type rq;
      bss_pkg::rsp_type none;
      none = '0;
      send_idle = s_idle;
      recv_idle = r_idle;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if (n % 40 == 0) random_settings();
         rq.operation = $urandom_range(1);
         if ($urandom_range(9) < 7) rq.query_epoch = $urandom_range(0, 40);
         else rq.query_epoch = $urandom_range(0, 65535);
         send_item(rq, 1'b0, none);
      end
   endtask

   // receiver stalls
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      bss_pkg::rsp_type ex;
      if (!reset && rsp_valid && rsp_ready) begin
         rsps_seen++;
         if (rsp_data.error) err_rsps++;
         if (expected_rsps.size() == 0) begin
            $error("result with no item outstanding: %h", rsp_data);
            fail_count++;
         end else begin
            ex = expected_rsps.pop_front();
            if (rsp_data.batch_size !== ex.batch_size) begin
               $error("batch_size: expected %0d, got %0d",
                      ex.batch_size, rsp_data.batch_size);
               fail_count++;
            end
            if (rsp_data.learning_rate !== ex.learning_rate) begin
               $error("learning_rate: expected %h, got %h",
                      ex.learning_rate, rsp_data.learning_rate);
               fail_count++;
            end
            if (rsp_data.epoch_now !== ex.epoch_now) begin
               $error("epoch_now: expected %0d, got %0d",
                      ex.epoch_now, rsp_data.epoch_now);
               fail_count++;
            end
            if (rsp_data.error !== ex.error) begin
               $error("error: expected %b, got %b", ex.error, rsp_data.error);
               fail_count++;
            end
         end
      end
   end

   // hang detection: cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", HANG_LIMIT);
         $display("** batch_size_scheduler: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      sh_mode = 1'b0;
      sh_base = 16'd1;
      sh_max = 16'd1;
      sh_step = 16'd1;
      sh_gamma = 32'h0100_0000;
      sh_lr = 32'd0;
      sh_lr_en = 1'b0;
      sh_epoch = 16'd0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      send_idle = 34;
      recv_idle = 66;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            drain_items();
            write_reg(dir_rows[i].idx, dir_rows[i].data);
         end else begin
            send_item(dir_rows[i].rq, dir_rows[i].chk, dir_rows[i].ex);
         end
      end

      random_phase(34, 66);
      random_phase(66, 34);
      random_phase(0, 0);

      drain_items();
      repeat (100) @(posedge clock);

      $display("%0d items sent, %0d results checked, %0d of them flagged as errors",
               items_sent, rsps_seen, err_rsps);
      $display("step and exponential modes, register extremes and three stall mixes covered");
      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("** batch_size_scheduler: PASSED **");
      end else begin
         $display("%0d mismatches, %0d results missing", fail_count, expected_rsps.size());
         $display("** batch_size_scheduler: FAILED **");
      end
      $finish;
   end

endmodule
